/* hdl/pdi_pkg.sv */
// ----------------------------------------------------------------------------
// pdi_pkg
// Shared widths, constants and types of the packed decimal to integer block.
// ----------------------------------------------------------------------------
package pdi_pkg;

  localparam int MaxDigits  = 31;
  localparam int NumDigits  = 32;
  localparam int NibW       = 4;
  localparam int HalfW      = 64;
  localparam int LaneDigits = 4;
  localparam int NumLanes   = NumDigits / LaneDigits;
  localparam int LaneW      = 15;
  localparam int Pair4W     = 28;
  localparam int Pair8W     = 54;
  localparam int ValW       = 64;
  localparam int NumStages  = 6;

  typedef logic [NumDigits-1:0][NibW-1:0] digits_t;
  typedef logic [LaneDigits-1:0][NibW-1:0] lane_digits_t;
  typedef logic [NumLanes-1:0][LaneW-1:0] lanes_t;
  typedef logic [NumStages-2:0] merge_en_t;

  typedef struct packed {
    logic neg;
    logic wide;
  } pdi_side_t;

endpackage

/* hdl/pdi_in_if.sv */
// ----------------------------------------------------------------------------
// pdi_in_if
// Input channel: one packed decimal number per transfer.
// ----------------------------------------------------------------------------
interface pdi_in_if;
  import pdi_pkg::*;

  logic             valid;
  logic             ready;
  logic [HalfW-1:0] packed_high;
  logic [HalfW-1:0] packed_low;

  modport source (output valid, output packed_high, output packed_low, input ready);
  modport sink (input valid, input packed_high, input packed_low, output ready);

endinterface

/* hdl/pdi_out_if.sv */
// ----------------------------------------------------------------------------
// pdi_out_if
// Output channel: one signed integer and overflow flag per transfer.
// ----------------------------------------------------------------------------
interface pdi_out_if;
  import pdi_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] value;
  logic                   overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);

endinterface

/* hdl/pdi_align.sv */
// ----------------------------------------------------------------------------
// pdi_align
// Picks the sign nibble and right-aligns the integer digits, zero filled.
// ----------------------------------------------------------------------------
module pdi_align (
  input  logic [pdi_pkg::HalfW-1:0] packed_high_i,
  input  logic [pdi_pkg::HalfW-1:0] packed_low_i,
  input  logic [4:0]                precision_i,
  input  logic [4:0]                scale_i,
  output pdi_pkg::digits_t          digits_o,
  output logic                      neg_o
);
  import pdi_pkg::*;

  localparam logic [NibW-1:0] SignMinusD = 4'hd;
  localparam logic [NibW-1:0] SignMinusB = 4'hb;

  logic [2*HalfW-1:0] word;
  digits_t            nib;
  logic [4:0]         prec;
  logic [4:0]         sign_pos;
  logic [NibW-1:0]    sign;
  logic [4:0]         count;
  logic               first;
  logic [5:0]         last;

  always_comb begin
    word = {packed_high_i, packed_low_i};
    for (int i = 0; i < NumDigits; i++) begin
      nib[i] = word[2*HalfW-1-NibW*i -: NibW];
    end
    prec     = (precision_i > 5'(MaxDigits)) ? 5'(MaxDigits) : precision_i;
    sign_pos = {prec[4:1], 1'b1};
    sign     = nib[sign_pos];
    neg_o    = (sign == SignMinusD) || (sign == SignMinusB);
    count    = (prec > scale_i) ? (prec - scale_i) : 5'd0;
    first    = ~prec[0];
    last     = 6'(first) + 6'(count) - 6'd1;
    for (int j = 0; j < NumDigits; j++) begin
      digits_o[j] = (6'(j) < {1'b0, count}) ? nib[5'(last - 6'(j))] : '0;
    end
  end

endmodule

/* hdl/pdi_lane.sv */
// ----------------------------------------------------------------------------
// pdi_lane
// Converts a group of decimal digits to binary.
// ----------------------------------------------------------------------------
module pdi_lane (
  input  pdi_pkg::lane_digits_t     digits_i,
  output logic [pdi_pkg::LaneW-1:0] value_o
);
  import pdi_pkg::*;

  logic [LaneW-1:0] acc;

  always_comb begin
    acc = '0;
    for (int k = LaneDigits - 1; k >= 0; k--) begin
      acc = LaneW'(acc * LaneW'(10)) + LaneW'(digits_i[k]);
    end
    value_o = acc;
  end

endmodule

/* hdl/pdi_merge.sv */
// ----------------------------------------------------------------------------
// pdi_merge
// Registered tree that joins lane values, then range check and sign.
// ----------------------------------------------------------------------------
module pdi_merge (
  input  logic                          clk_i,
  input  pdi_pkg::merge_en_t            en_i,
  input  pdi_pkg::lanes_t               lanes_i,
  input  pdi_pkg::pdi_side_t            side_i,
  output logic signed [pdi_pkg::ValW-1:0] value_o,
  output logic                          overflow_o
);
  import pdi_pkg::*;

  localparam int               HiW    = 10;
  localparam logic [13:0]      Ten4   = 14'd10000;
  localparam logic [26:0]      Ten8   = 27'd100000000;
  localparam logic [53:0]      Ten16  = 54'd10000000000000000;
  localparam logic [HiW-1:0]   HiMax  = 10'd922;
  localparam logic [ValW-1:0]  PosW64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [ValW-1:0]  NegW64 = 64'h8000_0000_0000_0000;
  localparam logic [ValW-1:0]  PosW32 = 64'h0000_0000_7fff_ffff;
  localparam logic [ValW-1:0]  NegW32 = 64'h0000_0000_8000_0000;

  lanes_t                         lanes_q;
  logic [3:0][Pair4W-1:0]         p4_d, p4_q;
  logic [1:0][Pair8W-1:0]         p8_d, p8_q;
  logic [ValW-1:0]                sum_d, sum_q;
  logic                           big_d, big_q;
  pdi_side_t [3:0]                side_q;
  logic [ValW-1:0]                limit;
  logic                           ovf_d;
  logic [ValW-1:0]                value_d;

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      p4_d[m] = Pair4W'(Pair4W'(lanes_q[2*m+1]) * Pair4W'(Ten4)) + Pair4W'(lanes_q[2*m]);
    end
    for (int n = 0; n < 2; n++) begin
      p8_d[n] = Pair8W'(Pair8W'(p4_q[2*n+1]) * Pair8W'(Ten8)) + Pair8W'(p4_q[2*n]);
    end
    big_d = p8_q[1] > Pair8W'(HiMax);
    sum_d = ValW'(ValW'(p8_q[1][HiW-1:0]) * ValW'(Ten16)) + ValW'(p8_q[0]);
    if (side_q[3].wide) begin
      limit = side_q[3].neg ? NegW64 : PosW64;
    end else begin
      limit = side_q[3].neg ? NegW32 : PosW32;
    end
    ovf_d   = big_q || (sum_q > limit);
    value_d = ovf_d ? '0 : (side_q[3].neg ? (ValW'(0) - sum_q) : sum_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lanes_q   <= lanes_i;
      side_q[0] <= side_i;
    end
    if (en_i[1]) begin
      p4_q      <= p4_d;
      side_q[1] <= side_q[0];
    end
    if (en_i[2]) begin
      p8_q      <= p8_d;
      side_q[2] <= side_q[1];
    end
    if (en_i[3]) begin
      sum_q     <= sum_d;
      big_q     <= big_d;
      side_q[3] <= side_q[2];
    end
    if (en_i[4]) begin
      value_o    <= value_d;
      overflow_o <= ovf_d;
    end
  end

endmodule

/* hdl/packed_decimal_to_integer_top.sv */
// ----------------------------------------------------------------------------
// packed_decimal_to_integer_top
// Packed decimal to signed binary integer converter with lane-parallel
// digit conversion and an APB register port.
//
//   channel   dir   transfer content
//   in_if     in    packed_high, packed_low
//   out_if    out   value, overflow
//   apb       in    precision (0x0), scale (0x4), result_wide (0x8)
//
// one item a cycle unless the output side holds off (out_if.ready low)
// alignment, digit lanes, a three-level merge tree and the range check are each a stage
// each stage moves on when it is empty or the next one moves, so bubbles close
// reset clears the stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module packed_decimal_to_integer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdi_in_if.sink      in_if,
  pdi_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pdi_pkg::*;

  typedef enum logic [1:0] {
    RegPrecision  = 2'd0,
    RegScale      = 2'd1,
    RegResultWide = 2'd2
  } reg_idx_e;

  logic [4:0]           precision_q;
  logic [4:0]           scale_q;
  logic                 wide_q;
  logic                 cfg_wr;
  reg_idx_e             reg_idx;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  digits_t              digits_d, digits_q;
  logic                 neg_d;
  pdi_side_t            side_q;
  lanes_t               lanes;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      RegPrecision:  prdata = 32'(precision_q);
      RegScale:      prdata = 32'(scale_q);
      RegResultWide: prdata = 32'(wide_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_q <= 5'd31;
      scale_q     <= 5'd0;
      wide_q      <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegPrecision:  precision_q <= pwdata[4:0];
        RegScale:      scale_q     <= pwdata[4:0];
        RegResultWide: wide_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // stage enables, from the output back to the input
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_if.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_if.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  pdi_align u_align (
    .packed_high_i (in_if.packed_high),
    .packed_low_i  (in_if.packed_low),
    .precision_i   (precision_q),
    .scale_i       (scale_q),
    .digits_o      (digits_d),
    .neg_o         (neg_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      digits_q    <= digits_d;
      side_q.neg  <= neg_d;
      side_q.wide <= wide_q;
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    pdi_lane u_lane (
      .digits_i (digits_q[LaneDigits*l +: LaneDigits]),
      .value_o  (lanes[l])
    );
  end

  pdi_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (en[NumStages-1:1]),
    .lanes_i    (lanes),
    .side_i     (side_q),
    .value_o    (out_if.value),
    .overflow_o (out_if.overflow)
  );

  assign out_if.valid = valid_q[NumStages-1];

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> valid_q[0])
    else $error("accepted transfer did not enter the first stage");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> ((&valid_q) && !out_if.ready))
    else $error("input stalled while the pipeline had room");

  a_overflow_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.overflow) |-> (out_if.value == '0))
    else $error("overflow result carries a non-zero value");

endmodule

/* tb/pdi_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_tb_pkg
// Register addresses, sign codes and the result record shared by the
// stimulus and the checker of the packed decimal converter bench.
// ----------------------------------------------------------------------------
package pdi_tb_pkg;
  import pdi_pkg::*;

  localparam logic [3:0] RegPrecision  = 4'h0;
  localparam logic [3:0] RegScale      = 4'h4;
  localparam logic [3:0] RegResultWide = 4'h8;

  localparam logic [3:0] SignPlusA  = 4'hA;
  localparam logic [3:0] SignMinusB = 4'hB;
  localparam logic [3:0] SignPlusC  = 4'hC;
  localparam logic [3:0] SignMinusD = 4'hD;
  localparam logic [3:0] SignPlusE  = 4'hE;
  localparam logic [3:0] SignPlusF  = 4'hF;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   overflow;
  } conv_result_t;

endpackage

/* tb/pdi_conversion_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_conversion_checker
// Watches the register port and both channels of the converter. Every input
// transfer is turned into an expected integer and overflow flag under the
// register values in force; every output transfer is compared field by field
// with the oldest expected result.
// ----------------------------------------------------------------------------
module pdi_conversion_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdi_in_if           in_mon,
  pdi_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned mismatches,
  output int unsigned pending
);
  import pdi_pkg::*;
  import pdi_tb_pkg::*;

  logic [4:0]   cfg_precision;
  logic [4:0]   cfg_scale;
  logic         cfg_wide;
  conv_result_t pending_integers[$];

  function automatic conv_result_t convert_packed(
    input logic [HalfW-1:0] high_half,
    input logic [HalfW-1:0] low_half,
    input logic [4:0]       precision,
    input logic [4:0]       scale,
    input logic             wide
  );
    logic [2*HalfW-1:0] whole;
    int unsigned        digits, first, count, k, pos;
    logic [3:0]         sign_nib, dig;
    logic               neg, ovf;
    logic [ValW-1:0]    limit, mag;
    conv_result_t       res;
    whole    = {high_half, low_half};
    digits   = (precision > MaxDigits) ? MaxDigits : precision;
    pos      = 2 * (digits / 2) + 1;
    sign_nib = whole[127 - 4*pos -: 4];
    neg      = (sign_nib == SignMinusD) || (sign_nib == SignMinusB);
    if (wide) begin
      limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    end else begin
      limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    end
    // even precision leaves a pad nibble in front
    first = (digits % 2 == 1) ? 0 : 1;
    count = (digits > scale) ? digits - scale : 0;
    ovf   = 1'b0;
    mag   = '0;
    for (k = 0; k < count; k++) begin
      pos = first + k;
      dig = whole[127 - 4*pos -: 4];
      if (!ovf) begin
        if (mag > limit / 10 || mag * 10 > limit - dig) begin
          ovf = 1'b1;
        end else begin
          mag = mag * 10 + dig;
        end
      end
    end
    res.overflow = ovf;
    res.value    = ovf ? '0 : (neg ? -mag : mag);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conv_result_t want;
    if (!rst_ni) begin
      cfg_precision <= 5'd31;
      cfg_scale     <= 5'd0;
      cfg_wide      <= 1'b1;
      pending_integers.delete();
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          RegPrecision:  cfg_precision <= pwdata[4:0];
          RegScale:      cfg_scale     <= pwdata[4:0];
          RegResultWide: cfg_wide      <= pwdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_integers.push_back(convert_packed(in_mon.packed_high, in_mon.packed_low,
                                                  cfg_precision, cfg_scale, cfg_wide));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_integers.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d overflow %0b",
                                    out_mon.value, out_mon.overflow));
        end else begin
          want = pending_integers.pop_front();
          if (out_mon.value !== want.value) begin
            report_mismatch($sformatf("value %0d, expected %0d", out_mon.value, want.value));
          end
          if (out_mon.overflow !== want.overflow) begin
            report_mismatch($sformatf("overflow %0b, expected %0b",
                                      out_mon.overflow, want.overflow));
          end
        end
      end
      pending = pending_integers.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the packed decimal converter with a directed set of edge values and
// sign codes, then with phases of random well-formed, corrupted and raw
// items under a range of precision, scale and width settings. Both channel
// ends idle in short bursts and the result side holds off twice long enough
// to back the pipeline up. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import pdi_pkg::*;
  import pdi_tb_pkg::*;

  localparam int unsigned LimitCycles  = 200000;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned PhaseItems   = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned hold_requests;
  int unsigned src_run_left;
  logic        quiet_tail = 1'b0;
  logic [4:0]  cur_precision;
  logic [4:0]  cur_scale;
  logic        cur_wide;

  pdi_in_if  in_ch ();
  pdi_out_if out_ch ();

  packed_decimal_to_integer_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pdi_conversion_checker u_conv_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_run_length();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 6);
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] pow10(input int unsigned n);
    logic [127:0] p;
    p = 128'd1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  // digits right-aligned in front of the sign nibble, filler elsewhere
  function automatic logic [127:0] encode_packed(input logic [127:0] mag,
                                                 input int unsigned digits,
                                                 input logic [3:0] sign_nib);
    logic [127:0] word;
    int unsigned  first, i, pos;
    word  = rand128();
    first = (digits % 2 == 1) ? 0 : 1;
    for (i = digits; i > 0; i--) begin
      pos = first + i - 1;
      word[127 - 4*pos -: 4] = 4'(mag % 10);
      mag = mag / 10;
    end
    pos = 2 * (digits / 2) + 1;
    word[127 - 4*pos -: 4] = sign_nib;
    return word;
  endfunction

  function automatic logic [3:0] pick_sign();
    case ($urandom_range(0, 5))
      0:       return SignPlusC;
      1:       return SignMinusD;
      2:       return SignPlusF;
      3:       return SignMinusB;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [127:0] pick_magnitude();
    logic [127:0] mag, bound;
    int unsigned  nd, i;
    mag = '0;
    case ($urandom_range(0, 2))
      0: begin
        nd = $urandom_range(0, cur_precision);
        for (i = 0; i < nd; i++) mag = mag * 10 + 128'($urandom_range(0, 9));
      end
      1: begin
        // integer part close to a range limit
        if ($urandom_range(0, 3) == 0) begin
          bound = cur_wide ? (128'd1 << 31) : (128'd1 << 63);
        end else begin
          bound = cur_wide ? (128'd1 << 63) : (128'd1 << 31);
        end
        bound = bound - 128'd2 + 128'($urandom_range(0, 4));
        mag = bound * pow10(cur_scale) + rand128() % pow10(cur_scale);
      end
      default: mag = pow10(cur_precision) - 128'd1 - 128'($urandom_range(0, 3));
    endcase
    return mag % pow10(cur_precision);
  endfunction

  function automatic logic [127:0] random_item();
    logic [127:0] word;
    int unsigned  r, first, pos;
    r = $urandom_range(0, 19);
    if (r < 3) return rand128();
    word = encode_packed(pick_magnitude(), cur_precision, pick_sign());
    if (r < 6 && cur_precision != 0) begin
      first = cur_precision[0] ? 0 : 1;
      pos   = first + $urandom_range(0, cur_precision - 1);
      word[127 - 4*pos -: 4] = 4'($urandom_range(10, 15));
    end
    return word;
  endfunction

  task automatic send_item(input logic [127:0] word);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail) begin
      if (src_run_left == 0) begin
        gap          = $urandom_range(1, 3);
        src_run_left = pick_run_length();
      end else begin
        src_run_left--;
      end
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.packed_high <= word[127:64];
    in_ch.packed_low  <= word[63:0];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // psel stays high between back-to-back writes, dropped by the caller
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_config(input logic [4:0] prec, input logic [4:0] scl, input logic wide);
    reg_write(RegPrecision, {27'd0, prec});
    reg_write(RegScale, {27'd0, scl});
    reg_write(RegResultWide, {31'd0, wide});
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    cur_precision = prec;
    cur_scale     = scl;
    cur_wide      = wide;
  endtask

  task automatic run_phase(input logic [4:0] prec, input logic [4:0] scl, input logic wide,
                           input bit with_hold);
    set_config(prec, scl, wide);
    if (with_hold) hold_requests <= hold_requests + 1;
    repeat (PhaseItems) send_item(random_item());
    drain_results();
  endtask

  // result side: idle bursts, long runs and the requested hold-offs
  initial begin : result_side
    int unsigned gap_left, run_left, hold_left, holds_done;
    gap_left   = 0;
    run_left   = 0;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HoldCycles - 1;
        out_ch.ready <= 1'b0;
      end else if (quiet_tail) begin
        out_ch.ready <= 1'b1;
      end else if (gap_left != 0) begin
        out_ch.ready <= 1'b0;
        gap_left--;
      end else if (run_left == 0) begin
        out_ch.ready <= 1'b0;
        gap_left = $urandom_range(0, 2);
        run_left = pick_run_length();
      end else begin
        out_ch.ready <= 1'b1;
        run_left--;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [127:0] word;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.packed_high <= '0;
    in_ch.packed_low  <= '0;
    cur_precision = 5'(MaxDigits);
    cur_scale     = 5'd0;
    cur_wide      = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: 31 digits, no fraction, 64-bit range
    send_item(128'd0);
    send_item(encode_packed(128'd0, MaxDigits, SignMinusD));
    send_item(encode_packed((128'd1 << 63) - 1, MaxDigits, SignPlusC));
    send_item(encode_packed(128'd1 << 63, MaxDigits, SignMinusD));
    send_item(encode_packed(128'd1 << 63, MaxDigits, SignPlusC));
    send_item(encode_packed((128'd1 << 63) + 1, MaxDigits, SignMinusB));
    send_item(encode_packed(pow10(MaxDigits) - 1, MaxDigits, SignPlusF));
    send_item(encode_packed(128'd12345, MaxDigits, SignPlusA));
    send_item(encode_packed(128'd12345, MaxDigits, SignMinusB));
    send_item(encode_packed(128'd12345, MaxDigits, SignPlusC));
    send_item(encode_packed(128'd12345, MaxDigits, SignMinusD));
    send_item(encode_packed(128'd12345, MaxDigits, SignPlusE));
    send_item(encode_packed(128'd12345, MaxDigits, SignPlusF));
    send_item(encode_packed(128'd12345, MaxDigits, 4'($urandom_range(0, 9))));
    // non-decimal nibble in the units place
    word = encode_packed(128'd100, MaxDigits, SignPlusC);
    word[127 - 4*30 -: 4] = 4'($urandom_range(10, 15));
    send_item(word);
    send_item({128{1'b1}});
    send_item({64{2'b10}});
    send_item({64{2'b01}});
    drain_results();

    // 32-bit range limits
    set_config(5'(MaxDigits), 5'd0, 1'b0);
    send_item(encode_packed((128'd1 << 31) - 1, MaxDigits, SignPlusC));
    send_item(encode_packed(128'd1 << 31, MaxDigits, SignMinusD));
    send_item(encode_packed(128'd1 << 31, MaxDigits, SignPlusC));
    send_item(encode_packed((128'd1 << 31) + 1, MaxDigits, SignMinusB));
    drain_results();

    run_phase(5'd31, 5'd0, 1'b1, 1'b1);
    run_phase(5'd31, 5'd0, 1'b0, 1'b0);
    run_phase(5'd19, 5'd0, 1'b1, 1'b0);
    run_phase(5'd10, 5'd0, 1'b0, 1'b0);
    run_phase(5'd0, 5'd0, 1'b1, 1'b0);
    run_phase(5'd1, 5'd0, 1'b0, 1'b0);
    run_phase(5'd31, 5'd31, 1'b1, 1'b1);
    run_phase(5'd12, 5'd15, 1'b0, 1'b0);
    run_phase(5'd24, 5'd5, 1'b1, 1'b0);
    run_phase(5'd20, 5'd1, 1'b0, 1'b0);
    repeat (2) begin
      run_phase(5'($urandom_range(0, 31)),
                ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 4)),
                1'($urandom_range(0, 1)), 1'b0);
    end
    quiet_tail <= 1'b1;
    run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 4)),
              1'($urandom_range(0, 1)), 1'b0);

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
